@@ rtl/core/pw_pkg.sv @@
`timescale 1ns / 1ps
package pw_pkg;

  localparam int COEF_W     = 48;
  localparam int COEF_COUNT = 8;
  localparam int IDX_W      = 4;
  localparam int COORD_W    = 9;
  localparam int CHAN_W     = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_WARP = 1'b1
  } op_t;

  // one request as it travels from the front through the queue to the back
  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } item_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic empty;
    logic almost_full;
  } q_status_t;

endpackage

@@ rtl/core/pw_front.sv @@
`timescale 1ns / 1ps
module pw_front #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 512,
  parameter int OUT_WIDTH  = 512,
  parameter int OUT_HEIGHT = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  pw_pkg::item_t  item_in,
  output logic           push,
  output pw_pkg::item_t  item_out
);

  localparam int LW = 13;

  logic [LW-1:0] xe, ye;
  logic          keep;

  assign xe = LW'(item_in.x);
  assign ye = LW'(item_in.y);

  // loads outside the source and warps outside the output raster are dropped
  always_comb begin
    unique case (item_in.op)
      pw_pkg::OP_LOAD: keep = (xe < LW'(SRC_WIDTH)) && (ye < LW'(SRC_HEIGHT));
      pw_pkg::OP_WARP: keep = (xe < LW'(OUT_WIDTH)) && (ye < LW'(OUT_HEIGHT));
      default:         keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= accept && keep;
    end
    item_out <= item_in;
  end

endmodule

@@ rtl/core/pw_queue.sv @@
`timescale 1ns / 1ps
module pw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pw_pkg::item_t     push_item,
  input  logic              pop,
  output pw_pkg::item_t     head,
  output pw_pkg::q_status_t status
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  pw_pkg::item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_pop;

  assign do_pop             = pop && (count != '0);
  assign head               = mem[rd_ptr];
  assign status.empty       = (count == '0);
  assign status.almost_full = (count >= (PW+1)'(DEPTH - 2));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end

endmodule

@@ rtl/core/pw_back.sv @@
`timescale 1ns / 1ps
module pw_back #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  pw_pkg::item_t                in_item,
  input  logic                         wr_en,
  input  logic [pw_pkg::IDX_W-1:0]     wr_index,
  input  logic [pw_pkg::COEF_W-1:0]    wr_data,
  output logic                         done,
  output logic [pw_pkg::CHAN_W-1:0]    out_red,
  output logic [pw_pkg::CHAN_W-1:0]    out_green,
  output logic [pw_pkg::CHAN_W-1:0]    out_blue,
  output logic                         in_range
);

  localparam int F    = FRAC_BITS;
  localparam int MAXD = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int IW   = $clog2(MAXD);
  localparam int QW   = IW + F;
  localparam int MW   = 61;
  localparam int RW   = MW + QW;
  localparam int CW   = ((IW > pw_pkg::COORD_W) ? IW : pw_pkg::COORD_W) + 1;
  localparam int BWR  = $clog2((SRC_WIDTH + 1) / 2);
  localparam int BHR  = $clog2((SRC_HEIGHT + 1) / 2);
  localparam int BWB  = (BWR < 1) ? 1 : BWR;
  localparam int BHB  = (BHR < 1) ? 1 : BHR;
  localparam int AW   = BWB + BHB;
  localparam int WW   = 2 * F + 2;
  localparam int PRW  = WW + pw_pkg::CHAN_W;
  localparam int ACW  = PRW + 2;
  localparam int CI_W = $clog2(pw_pkg::COEF_COUNT);
  localparam int PXW  = 3 * pw_pkg::CHAN_W;

  localparam int REG_A = 0;
  localparam int REG_B = 1;
  localparam int REG_C = 2;
  localparam int REG_D = 3;
  localparam int REG_E = 4;
  localparam int REG_F = 5;
  localparam int REG_G = 6;
  localparam int REG_H = 7;

  localparam logic signed [pw_pkg::COEF_W-1:0] COEF_ONE = 48'sh0001_0000_0000;
  localparam logic signed [MW-1:0]             ONE_Q32  = 61'sh1_0000_0000;
  localparam logic [F:0]                       S_ONE    = (F+1)'(1) << F;

  // coefficient registers
  logic signed [pw_pkg::COEF_W-1:0] coef [pw_pkg::COEF_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pw_pkg::COEF_COUNT; i++) begin
        coef[i] <= '0;
      end
      coef[REG_A] <= COEF_ONE;
      coef[REG_E] <= COEF_ONE;
    end else if (wr_en && (wr_index < pw_pkg::IDX_W'(pw_pkg::COEF_COUNT))) begin
      coef[wr_index[CI_W-1:0]] <= wr_data;
    end
  end

  // products of coefficients and output coordinate
  logic signed [9:0]  xs, ys;
  logic               p_vld;
  pw_pkg::item_t      p_item;
  logic signed [57:0] p_ax, p_by, p_dx, p_ey, p_gx, p_hy;
  logic signed [pw_pkg::COEF_W-1:0] p_c, p_f;

  assign xs = signed'({1'b0, in_item.x});
  assign ys = signed'({1'b0, in_item.y});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= in_valid;
    end
    p_item <= in_item;
    p_ax   <= coef[REG_A] * xs;
    p_by   <= coef[REG_B] * ys;
    p_dx   <= coef[REG_D] * xs;
    p_ey   <= coef[REG_E] * ys;
    p_gx   <= coef[REG_G] * xs;
    p_hy   <= coef[REG_H] * ys;
    p_c    <= coef[REG_C];
    p_f    <= coef[REG_F];
  end

  // numerators and denominator
  logic                 s_vld;
  pw_pkg::item_t        s_item;
  logic signed [MW-1:0] s_numx, s_numy, s_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= p_vld;
    end
    s_item <= p_item;
    s_numx <= MW'(p_ax) + MW'(p_by) + MW'(p_c);
    s_numy <= MW'(p_dx) + MW'(p_ey) + MW'(p_f);
    s_den  <= MW'(p_gx) + MW'(p_hy) + ONE_Q32;
  end

  // sign normalization: make the denominator positive
  logic signed [MW-1:0] nrm_x, nrm_y, nrm_d;
  logic                 n_vld, n_bad;
  pw_pkg::item_t        n_item;
  logic [MW-1:0]        n_x, n_y, n_d;

  assign nrm_x = s_den[MW-1] ? -s_numx : s_numx;
  assign nrm_y = s_den[MW-1] ? -s_numy : s_numy;
  assign nrm_d = s_den[MW-1] ? -s_den  : s_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else begin
      n_vld <= s_vld;
    end
    n_item <= s_item;
    n_bad  <= (s_den == '0) || nrm_x[MW-1] || nrm_y[MW-1];
    n_x    <= unsigned'(nrm_x);
    n_y    <= unsigned'(nrm_y);
    n_d    <= unsigned'(nrm_d);
  end

  // divider pipeline, one quotient bit per stage
  logic          dv_vld  [QW+1];
  pw_pkg::item_t dv_item [QW+1];
  logic          dv_bad  [QW+1];
  logic [QW-1:0] dv_qx   [QW+1];
  logic [QW-1:0] dv_qy   [QW+1];
  logic [RW-1:0] dv_rx   [QW];
  logic [RW-1:0] dv_ry   [QW];
  logic [MW-1:0] dv_d    [QW];

  // quotient must stay below 2^IW before the fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= n_vld;
    end
    dv_item[0] <= n_item;
    dv_bad[0]  <= n_bad || ({{IW{1'b0}}, n_x} >= {n_d, {IW{1'b0}}})
                        || ({{IW{1'b0}}, n_y} >= {n_d, {IW{1'b0}}});
    dv_qx[0]   <= '0;
    dv_qy[0]   <= '0;
    dv_rx[0]   <= {{IW{1'b0}}, n_x, {F{1'b0}}};
    dv_ry[0]   <= {{IW{1'b0}}, n_y, {F{1'b0}}};
    dv_d[0]    <= n_d;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [RW-1:0] dsh;
    logic          bit_x, bit_y;

    assign dsh   = {{QW{1'b0}}, dv_d[j]} << K;
    assign bit_x = dv_rx[j] >= dsh;
    assign bit_y = dv_ry[j] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else begin
        dv_vld[j+1] <= dv_vld[j];
      end
      dv_item[j+1] <= dv_item[j];
      dv_bad[j+1]  <= dv_bad[j];
      dv_qx[j+1]   <= {dv_qx[j][QW-2:0], bit_x};
      dv_qy[j+1]   <= {dv_qy[j][QW-2:0], bit_y};
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        dv_rx[j+1] <= bit_x ? (dv_rx[j] - dsh) : dv_rx[j];
        dv_ry[j+1] <= bit_y ? (dv_ry[j] - dsh) : dv_ry[j];
        dv_d[j+1]  <= dv_d[j];
      end
    end
  end

  // split quotient, range and edge checks
  logic [IW-1:0] ix, iy;
  logic [F-1:0]  fx, fy;
  logic          pt_ok, edge_r, edge_b, is_warp, is_load;
  logic [CW-1:0] ix_e, iy_e, ix_p1, iy_p1, lx, ly;
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [1:0]    wbank;
  logic [PXW-1:0] wdata;

  assign ix      = dv_qx[QW][QW-1:F];
  assign iy      = dv_qy[QW][QW-1:F];
  assign fx      = dv_qx[QW][F-1:0];
  assign fy      = dv_qy[QW][F-1:0];
  assign pt_ok   = !dv_bad[QW] && ({1'b0, ix} < (IW+1)'(SRC_WIDTH))
                               && ({1'b0, iy} < (IW+1)'(SRC_HEIGHT));
  assign edge_r  = (ix == IW'(SRC_WIDTH - 1));
  assign edge_b  = (iy == IW'(SRC_HEIGHT - 1));
  assign is_warp = dv_vld[QW] && (dv_item[QW].op == pw_pkg::OP_WARP);
  assign is_load = dv_vld[QW] && (dv_item[QW].op == pw_pkg::OP_LOAD);
  assign ix_e    = CW'(ix);
  assign iy_e    = CW'(iy);
  assign ix_p1   = ix_e + CW'(1);
  assign iy_p1   = iy_e + CW'(1);
  assign lx      = CW'(dv_item[QW].x);
  assign ly      = CW'(dv_item[QW].y);
  assign waddr   = {ly[BHB:1], lx[BWB:1]};
  assign wbank   = {dv_item[QW].y[0], dv_item[QW].x[0]};
  assign wdata   = {dv_item[QW].red, dv_item[QW].green, dv_item[QW].blue};

  // source image in four banks by row and column parity
  logic [PXW-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = ((b % 2) == 1);
    localparam logic BY = ((b / 2) == 1);
    logic [PXW-1:0] mem [2**AW];
    logic [CW-1:0]  col, row;

    assign col      = (ix[0] == BX) ? ix_e : ix_p1;
    assign row      = (iy[0] == BY) ? iy_e : iy_p1;
    assign raddr[b] = {row[BHB:1], col[BWB:1]};

    always_ff @(posedge clk) begin
      if (is_load && (wbank == 2'(b))) begin
        mem[waddr] <= wdata;
      end
      rd[b] <= mem[raddr[b]];
    end
  end

  // registered alongside the bank read
  logic         a_res, a_ok, a_er, a_eb, a_px, a_py;
  logic [F-1:0] a_fx, a_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_res <= 1'b0;
    end else begin
      a_res <= is_warp;
    end
    a_ok <= pt_ok;
    a_er <= edge_r;
    a_eb <= edge_b;
    a_px <= ix[0];
    a_py <= iy[0];
    a_fx <= edge_r ? '0 : fx;
    a_fy <= edge_b ? '0 : fy;
  end

  // neighbor select and weights
  logic [PXW-1:0] h0, h0n, h1, h1n, s00, s01, s10, s11;
  logic [F:0]     wx0, wy0, fxe, fye;

  assign h0  = a_px ? rd[1] : rd[0];
  assign h0n = a_px ? rd[0] : rd[1];
  assign h1  = a_px ? rd[3] : rd[2];
  assign h1n = a_px ? rd[2] : rd[3];
  assign s00 = a_py ? h1  : h0;
  assign s10 = a_py ? h1n : h0n;
  assign s01 = a_py ? h0  : h1;
  assign s11 = a_py ? h0n : h1n;
  assign fxe = (F+1)'(a_fx);
  assign fye = (F+1)'(a_fy);
  assign wx0 = S_ONE - fxe;
  assign wy0 = S_ONE - fye;

  logic           w_res, w_ok;
  logic [PXW-1:0] w_p [4];
  logic [WW-1:0]  w_w [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      w_res <= 1'b0;
    end else begin
      w_res <= a_res;
    end
    w_ok   <= a_ok;
    w_p[0] <= a_ok ? s00 : '0;
    w_p[1] <= (a_ok && !a_eb) ? s01 : '0;
    w_p[2] <= (a_ok && !a_er) ? s10 : '0;
    w_p[3] <= (a_ok && !a_er && !a_eb) ? s11 : '0;
    w_w[0] <= WW'(wx0 * wy0);
    w_w[1] <= WW'(wx0 * fye);
    w_w[2] <= WW'(fxe * wy0);
    w_w[3] <= WW'(fxe * fye);
  end

  // per-channel weighted terms
  logic           m_res, m_ok;
  logic [PRW-1:0] m_t [3][4];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    localparam int SH = 2 * pw_pkg::CHAN_W - pw_pkg::CHAN_W * c;
    for (genvar n = 0; n < 4; n++) begin : g_term
      always_ff @(posedge clk) begin
        m_t[c][n] <= PRW'(w_p[n][SH +: pw_pkg::CHAN_W]) * PRW'(w_w[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_res <= 1'b0;
    end else begin
      m_res <= w_res;
    end
    m_ok <= w_ok;
  end

  // blend sum and result register
  logic [ACW-1:0] acc [3];

  for (genvar c = 0; c < 3; c++) begin : g_acc
    assign acc[c] = ACW'(m_t[c][0]) + ACW'(m_t[c][1]) + ACW'(m_t[c][2]) + ACW'(m_t[c][3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_res;
    end
    out_red   <= acc[0][2*F +: pw_pkg::CHAN_W];
    out_green <= acc[1][2*F +: pw_pkg::CHAN_W];
    out_blue  <= acc[2][2*F +: pw_pkg::CHAN_W];
    in_range  <= m_ok;
  end

endmodule

@@ rtl/core/perspective_warp_bilinear.sv @@
`timescale 1ns / 1ps
// Perspective warp of a stored RGB source image with bilinear blending.
// Requests enter on start/operation/pixel_x/pixel_y/load_*; one is taken at
// each rising edge with start high and busy low. A load request writes one
// source pixel and gives no result; a warp request gives one result pixel.
// Loads outside the source and warps outside the output raster are dropped.
// Coefficients are written through wr_en/wr_index/wr_data while idle.
// Results appear on out_red/out_green/out_blue/in_range for one cycle with
// done high. The receiver cannot stall; nothing is held back.
// Throughput: one request per cycle; busy stays low in steady streaming.
// From the accepting edge to done a request passes the front register, the
// queue, the product, sum and sign-normalization registers, the pipelined
// restoring divider (input register, then one quotient bit per stage for
// QW = clog2(max(SRC_WIDTH, SRC_HEIGHT)) + FRAC_BITS bits, 17 at defaults),
// the registered read of the four parity banks, then weight, term and result.
// Reset clears the pipeline, the queue and the coefficients (identity map);
// the source image is undefined until loaded.
module perspective_warp_bilinear #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 512,
  parameter int OUT_WIDTH  = 512,
  parameter int OUT_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [pw_pkg::COORD_W-1:0]   pixel_x,
  input  logic [pw_pkg::COORD_W-1:0]   pixel_y,
  input  logic [pw_pkg::CHAN_W-1:0]    load_red,
  input  logic [pw_pkg::CHAN_W-1:0]    load_green,
  input  logic [pw_pkg::CHAN_W-1:0]    load_blue,
  input  logic                         wr_en,
  input  logic [pw_pkg::IDX_W-1:0]     wr_index,
  input  logic [pw_pkg::COEF_W-1:0]    wr_data,
  output logic                         done,
  output logic [pw_pkg::CHAN_W-1:0]    out_red,
  output logic [pw_pkg::CHAN_W-1:0]    out_green,
  output logic [pw_pkg::CHAN_W-1:0]    out_blue,
  output logic                         in_range
);

  pw_pkg::item_t     req, fr_item, q_head;
  pw_pkg::q_status_t q_stat;
  logic              accept, fr_push;

  assign accept = start && !busy;
  assign busy   = q_stat.almost_full;

  // request bundle
  always_comb begin
    req.op    = pw_pkg::op_t'(operation);
    req.x     = pixel_x;
    req.y     = pixel_y;
    req.red   = load_red;
    req.green = load_green;
    req.blue  = load_blue;
  end

  pw_front #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .OUT_WIDTH (OUT_WIDTH),
    .OUT_HEIGHT(OUT_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item_in (req),
    .push    (fr_push),
    .item_out(fr_item)
  );

  pw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fr_push),
    .push_item(fr_item),
    .pop      (!q_stat.empty),
    .head     (q_head),
    .status   (q_stat)
  );

  pw_back #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_stat.empty),
    .in_item  (q_head),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .in_range (in_range)
  );

endmodule

@@ rtl/core/pw_checker.sv @@
`timescale 1ns / 1ps
module pw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       operation,
  input logic                       done,
  input logic [pw_pkg::CHAN_W-1:0]  out_red,
  input logic [pw_pkg::CHAN_W-1:0]  out_green,
  input logic [pw_pkg::CHAN_W-1:0]  out_blue,
  input logic                       in_range
);

  // no result right after reset
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // ready right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // a point outside the source reads black
  a_black_outside: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("out-of-range result is not black");

  // a load request taken right after reset cannot produce a result next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && start && !busy && operation == pw_pkg::OP_LOAD) |=> !done)
    else $error("result strobe following a load after reset");

endmodule

bind perspective_warp_bilinear pw_checker u_pw_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int IMG_W   = 512;
  localparam int IMG_H   = 512;
  localparam int FRAC    = 8;
  localparam int LATENCY = 40;
  localparam int LIMIT   = 400000;
  localparam longint ONE = 64'sd4294967296;

  localparam int IDX_A = 0, IDX_B = 1, IDX_C = 2, IDX_D = 3;
  localparam int IDX_E = 4, IDX_F = 5, IDX_G = 6, IDX_H = 7;
  localparam int IDX_BAD = 11;

  typedef struct packed {
    logic [pw_pkg::CHAN_W-1:0] red;
    logic [pw_pkg::CHAN_W-1:0] green;
    logic [pw_pkg::CHAN_W-1:0] blue;
    logic                      in_img;
  } pixel_out_t;

  logic clk = 0, rst = 1;
  logic start = 0, busy, operation = 0;
  logic [pw_pkg::COORD_W-1:0] pixel_x = '0, pixel_y = '0;
  logic [pw_pkg::CHAN_W-1:0] load_red = '0, load_green = '0, load_blue = '0;
  logic wr_en = 0;
  logic [pw_pkg::IDX_W-1:0] wr_index = '0;
  logic [pw_pkg::COEF_W-1:0] wr_data = '0;
  logic done, in_range;
  logic [pw_pkg::CHAN_W-1:0] out_red, out_green, out_blue;

  perspective_warp_bilinear u_dut (.*);

  // shadow copy of the block state
  logic [23:0] image_mem [0:IMG_W*IMG_H-1];
  bit          loaded    [0:IMG_W*IMG_H-1];
  longint      coef      [0:pw_pkg::COEF_COUNT-1];

  pixel_out_t expected_pixels[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  steady = 0;

  initial forever #4 clk = ~clk;

  // run-time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_out_t got, want;
    if (!rst && done) begin
      got = '{out_red, out_green, out_blue, in_range};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch: expected r%0d g%0d b%0d in%0d, ",
                      "got r%0d g%0d b%0d in%0d"},
                     want.red, want.green, want.blue, want.in_img,
                     got.red, got.green, got.blue, got.in_img);
        end
      end
    end
  end

  // floor division to integer part and fraction, false when off the image
  function automatic bit map_coord(longint num, longint den, int lim,
                                   output int ipart, output int frac);
    longint unsigned n, d, q, r;
    ipart = 0;
    frac = 0;
    if (den == 0) return 0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0) return 0;
    n = num;
    d = den;
    q = n / d;
    if (q >= lim) return 0;
    r = n % d;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= d) begin
        r -= d;
        frac |= 1;
      end
    end
    ipart = int'(q);
    return 1;
  endfunction

  // warp one output coordinate; safe is cleared if an unloaded pixel is read
  function automatic pixel_out_t warp_pixel(int x, int y, output bit safe);
    pixel_out_t res;
    longint den, nx, ny, acc;
    int ix, iy, fx, fy, a00, a01, a10, a11;
    logic [23:0] p00, p01, p10, p11;
    res = '0;
    safe = 1;
    den = coef[IDX_G] * x + coef[IDX_H] * y + ONE;
    nx  = coef[IDX_A] * x + coef[IDX_B] * y + coef[IDX_C];
    ny  = coef[IDX_D] * x + coef[IDX_E] * y + coef[IDX_F];
    if (!map_coord(nx, den, IMG_W, ix, fx) || !map_coord(ny, den, IMG_H, iy, fy))
      return res;
    a00 = iy * IMG_W + ix;
    a01 = a00 + IMG_W;
    a10 = a00 + 1;
    a11 = a01 + 1;
    p00 = image_mem[a00];
    p01 = '0;
    p10 = '0;
    p11 = '0;
    safe = loaded[a00];
    if (iy < IMG_H - 1) begin
      p01 = image_mem[a01];
      safe &= loaded[a01];
    end else fy = 0;
    if (ix < IMG_W - 1) begin
      p10 = image_mem[a10];
      safe &= loaded[a10];
    end else fx = 0;
    if (iy < IMG_H - 1 && ix < IMG_W - 1) begin
      p11 = image_mem[a11];
      safe &= loaded[a11];
    end
    for (int k = 0; k < 3; k++) begin
      int sh;
      sh = 16 - 8 * k;
      acc = longint'((p00 >> sh) & 8'hFF) * (256 - fx) * (256 - fy)
          + longint'((p01 >> sh) & 8'hFF) * (256 - fx) * fy
          + longint'((p10 >> sh) & 8'hFF) * fx * (256 - fy)
          + longint'((p11 >> sh) & 8'hFF) * fx * fy;
      if (k == 0) res.red = pw_pkg::CHAN_W'(acc >> 16);
      else if (k == 1) res.green = pw_pkg::CHAN_W'(acc >> 16);
      else res.blue = pw_pkg::CHAN_W'(acc >> 16);
    end
    res.in_img = 1;
    return res;
  endfunction

  // one request, held until the block takes it, then predicted
  task automatic send_request(pw_pkg::op_t op, int x, int y, int r, int g, int b);
    bit ok;
    pixel_out_t want;
    start <= 1;
    operation <= op;
    pixel_x <= pw_pkg::COORD_W'(x);
    pixel_y <= pw_pkg::COORD_W'(y);
    load_red <= pw_pkg::CHAN_W'(r);
    load_green <= pw_pkg::CHAN_W'(g);
    load_blue <= pw_pkg::CHAN_W'(b);
    do @(posedge clk); while (busy);
    if (op == pw_pkg::OP_LOAD) begin
      image_mem[y * IMG_W + x] = {8'(r), 8'(g), 8'(b)};
      loaded[y * IMG_W + x] = 1;
    end else begin
      want = warp_pixel(x, y, ok);
      expected_pixels = {expected_pixels, want};
    end
    if (!steady && $urandom_range(99) < 19) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic load_pixel(int x, int y);
    send_request(pw_pkg::OP_LOAD, x, y, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
  endtask

  // drain outstanding results, then let loads settle before a register write
  task automatic wait_idle();
    start <= 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_coefs(longint a, longint b, longint c, longint d,
                             longint e, longint f, longint g, longint h);
    longint vals[pw_pkg::COEF_COUNT];
    vals = '{a, b, c, d, e, f, g, h};
    wait_idle();
    for (int i = 0; i < pw_pkg::COEF_COUNT; i++) begin
      wr_en <= 1;
      wr_index <= pw_pkg::IDX_W'(i);
      wr_data <= vals[i][pw_pkg::COEF_W-1:0];
      @(posedge clk);
      coef[i] = longint'(signed'(vals[i][pw_pkg::COEF_W-1:0]));
    end
    wr_en <= 0;
    @(posedge clk);
  endtask

  // fill a square block of the source image
  task automatic load_block(int x0, int y0, int size);
    for (int y = y0; y < y0 + size; y++)
      for (int x = x0; x < x0 + size; x++) load_pixel(x, y);
  endtask

  // mixed traffic: warps whose reads are all loaded, and loads
  task automatic random_traffic(int count);
    int x, y;
    bit ok, sent;
    pixel_out_t dummy;
    for (int n = 0; n < count; n++) begin
      sent = 0;
      if ($urandom_range(99) < 70) begin
        for (int t = 0; t < 40 && !sent; t++) begin
          x = $urandom_range(511);
          y = $urandom_range(511);
          if ($urandom_range(1)) begin
            x = $urandom_range(20);
            y = $urandom_range(20);
          end
          dummy = warp_pixel(x, y, ok);
          if (ok) begin
            send_request(pw_pkg::OP_WARP, x, y, $urandom_range(255),
                         $urandom_range(255), $urandom_range(255));
            sent = 1;
          end
        end
      end
      if (!sent) begin
        if ($urandom_range(3) == 0) load_pixel($urandom_range(511), $urandom_range(511));
        else load_pixel($urandom_range(15) + ($urandom_range(1) ? 496 : 0),
                        $urandom_range(15) + ($urandom_range(1) ? 496 : 0));
      end
    end
  endtask

  // identity map: corners, edges and the loaded windows
  task automatic test_identity();
    load_block(0, 0, 16);
    load_block(508, 0, 4);
    load_block(0, 508, 4);
    load_block(508, 508, 4);
    send_request(pw_pkg::OP_LOAD, 0, 0, 0, 0, 0);
    send_request(pw_pkg::OP_LOAD, 511, 511, 255, 255, 255);
    send_request(pw_pkg::OP_WARP, 0, 0, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 511, 511, 255, 255, 255);
    send_request(pw_pkg::OP_WARP, 511, 0, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 0, 511, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 7, 9, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 509, 2, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 2, 509, 0, 0, 0);
    random_traffic(10);
  endtask

  // downscale with fractional offsets lands inside the first window
  task automatic test_scaled();
    write_coefs(64'sd1 <<< 27, 64'sd3 <<< 22, 64'sd5 <<< 30, -(64'sd1 <<< 21),
                64'sd1 <<< 27, (64'sd3 <<< 31) + 12345, 0, 0);
    send_request(pw_pkg::OP_WARP, 0, 0, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 160, 160, 0, 0, 0);
    steady = 1;
    random_traffic(40);
    steady = 0;
    // hold off until the pipeline has drained
    start <= 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    random_traffic(10);
  endtask

  // true perspective, offset into the right edge, and a negative denominator
  task automatic test_projective();
    write_coefs(64'sd1 <<< 28, 0, 64'sd504 <<< 32, 0, 64'sd1 <<< 28, 64'sd3 <<< 31,
                64'sd1 <<< 20, 64'sd1 <<< 19);
    random_traffic(15);
    write_coefs(-(64'sd1 <<< 31), 0, 0, 0, -(64'sd1 <<< 31), 0,
                -(64'sd1 <<< 34), -(64'sd1 <<< 34));
    random_traffic(15);
  endtask

  // zero denominator, extreme coefficients and an out-of-range index
  task automatic test_degenerate();
    write_coefs(ONE, 0, 0, 0, ONE, 0, -ONE, 0);
    send_request(pw_pkg::OP_WARP, 1, 5, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 1, 0, 0, 0, 0);
    random_traffic(5);
    write_coefs((64'sd1 <<< 47) - 1, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1,
                -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1, -(64'sd1 <<< 47),
                (64'sd1 <<< 47) - 1, -(64'sd1 <<< 47));
    send_request(pw_pkg::OP_WARP, 0, 0, 0, 0, 0);
    send_request(pw_pkg::OP_WARP, 511, 511, 0, 0, 0);
    random_traffic(5);
    write_coefs(-(64'sd1 <<< 47), (64'sd1 <<< 47) - 1, -(64'sd1 <<< 47),
                (64'sd1 <<< 47) - 1, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1,
                -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    random_traffic(5);
    // ignored write, identity stays in force
    write_coefs(ONE, 0, 0, 0, ONE, 0, 0, 0);
    wr_en <= 1;
    wr_index <= pw_pkg::IDX_W'(IDX_BAD);
    wr_data <= {pw_pkg::COEF_W{1'b1}};
    @(posedge clk);
    wr_en <= 0;
    random_traffic(5);
  endtask

  // random coefficients, mostly off the image
  task automatic test_random_coefs();
    longint v[pw_pkg::COEF_COUNT];
    for (int p = 0; p < 3; p++) begin
      foreach (v[i]) v[i] = longint'(signed'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF));
      write_coefs(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
      random_traffic(5);
    end
  endtask

  initial begin
    foreach (loaded[i]) loaded[i] = 0;
    foreach (coef[i]) coef[i] = 0;
    coef[IDX_A] = ONE;
    coef[IDX_E] = ONE;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_identity();
    test_scaled();
    test_projective();
    test_degenerate();
    test_random_coefs();
    wait_idle();
    if (mismatches == 0 && expected_pixels.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/pw_pkg.sv
rtl/core/pw_front.sv
rtl/core/pw_queue.sv
rtl/core/pw_back.sv
rtl/core/perspective_warp_bilinear.sv
rtl/core/pw_checker.sv
dv/testbench.sv
